// ===== design/prt_pkg.sv =====
// prt_pkg: shared types and constants of the prescaled reload timer
// no dependencies; used by the interface users, the timer core and the top level
package prt_pkg;

  // operation codes carried by an item
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  // register select
  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_STATUS  = 2'd1,
    REG_COUNT   = 2'd2,
    REG_RELOAD  = 2'd3
  } reg_e;

  // control word layout
  localparam int unsigned CTL_ENABLE_BIT   = 0;
  localparam int unsigned CTL_LOAD_BIT     = 1;
  localparam int unsigned CTL_AUTO_BIT     = 2;
  localparam int unsigned CTL_IE_BIT       = 3;
  localparam int unsigned CTL_PRESCALE_LSB = 4;

  // status word layout
  localparam int unsigned STS_FLAG_BIT = 0;

  // input item
  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  reg_index;
    logic [15:0] write_value;
    logic [15:0] tick_count;
  } item_t;

  // result item
  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_raise;
    logic        irq_lower;
  } result_t;

endpackage

// ===== design/prt_stream_if.sv =====
// prt_stream_if: valid/ready channel carrying one payload per item
// payload type is a parameter; used with prt_pkg::item_t and prt_pkg::result_t
interface prt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/prescaled_reload_timer_unit.sv =====
// prescaled_reload_timer_unit: top level, input register, timer core, result register
// depends on prt_pkg, prt_stream_if and prt_timer
//
// Down-counting timer behind control, status, count and reload registers. Each
// item is a tick event, a register read or a register write and yields exactly
// one result item. One item is taken every clock cycle unless the result side
// stalls; an item passes the input register, then the timer core's state update
// into the result register. The result register and the input register each
// hold an item, so a stalled result side still lets one more item in. Prescaling
// is a shift by the control word's exponent, with the remainder kept in an
// accumulator. State resets to zero with no clearing pass.
module prescaled_reload_timer_unit #(
  parameter int unsigned COUNT_WIDTH   = 16,
  parameter int unsigned PRESCALE_BITS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  prt_stream_if.sink   item_i,
  prt_stream_if.source result_o
);
  import prt_pkg::*;

  logic    in_vld_q, in_vld_d;
  item_t   in_data_q;
  logic    out_vld_q, out_vld_d;
  result_t out_data_q;
  result_t core_res;
  logic    out_free;
  logic    fire;
  logic    accept;

  // handshake
  assign out_free     = !out_vld_q || result_o.ready;
  assign fire         = in_vld_q && out_free;
  assign item_i.ready = !in_vld_q || out_free;
  assign accept       = item_i.valid && item_i.ready;

  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_data_q;

  // timer core
  prt_timer #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .PRESCALE_BITS (PRESCALE_BITS)
  ) u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_data_q),
    .result_o (core_res)
  );

  // stage valids
  always_comb begin
    in_vld_d  = in_vld_q;
    out_vld_d = out_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (result_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= item_i.data;
    end
    if (fire) begin
      out_data_q <= core_res;
    end
  end

  // a processed item shows up as a result next cycle
  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("processed item missing from result register");

  // raise and lower never come from the same item
  a_irq_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_data_q.irq_raise && out_data_q.irq_lower))
    else $error("irq raise and lower in one result");

  // input register never overwritten while its item is pending
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !fire |-> !accept)
    else $error("input register overwritten");

endmodule

// ===== design/prt_timer.sv =====
// prt_timer: timer register file, prescaler and down counter, one item per cycle while fire_i is high
// depends on prt_pkg; state updates on fire_i, result is combinational from the item and the current state
module prt_timer #(
  parameter int unsigned COUNT_WIDTH   = 16,
  parameter int unsigned PRESCALE_BITS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  prt_pkg::item_t  item_i,
  output prt_pkg::result_t result_o
);
  import prt_pkg::*;

  // compare width covers both the counter and the 17-bit step count
  localparam int unsigned CMP_W = (COUNT_WIDTH > 17) ? COUNT_WIDTH : 17;

  logic [15:0]              ctrl_q, ctrl_d;
  logic                     flag_q, flag_d;
  logic [COUNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0]   rel_q, rel_d;
  logic [15:0]              acc_q, acc_d;

  op_e                      op;
  reg_e                     rsel;
  logic [PRESCALE_BITS-1:0] pexp;
  logic [15:0]              scale;
  logic [15:0]              rem;
  logic [15:0]              quot;
  logic [16:0]              acc_sum;
  logic                     carry;
  logic [15:0]              acc_next;
  logic [16:0]              steps;
  logic [CMP_W-1:0]         steps_w;
  logic [CMP_W-1:0]         cnt_w;
  logic                     expire;
  logic [COUNT_WIDTH-1:0]   over;
  logic [COUNT_WIDTH-1:0]   cnt_dec;

  assign op   = op_e'(item_i.operation);
  assign rsel = reg_e'(item_i.reg_index);

  // prescaler: quotient by shift, remainder into the accumulator
  assign pexp     = ctrl_q[CTL_PRESCALE_LSB +: PRESCALE_BITS];
  assign scale    = 16'd1 << pexp;
  assign rem      = item_i.tick_count & (scale - 16'd1);
  assign quot     = item_i.tick_count >> pexp;
  assign acc_sum  = {1'b0, acc_q} + {1'b0, rem};
  assign carry    = (acc_sum >= {1'b0, scale});
  assign acc_next = carry ? 16'(acc_sum - {1'b0, scale}) : acc_sum[15:0];
  assign steps    = {1'b0, quot} + {16'd0, carry};

  // down counter: decrement or expire with overshoot
  assign steps_w = CMP_W'(steps);
  assign cnt_w   = CMP_W'(cnt_q);
  assign expire  = !(cnt_w > steps_w);
  assign over    = COUNT_WIDTH'(steps_w - cnt_w);
  assign cnt_dec = COUNT_WIDTH'(cnt_w - steps_w);

  // next state and result
  always_comb begin
    ctrl_d   = ctrl_q;
    flag_d   = flag_q;
    cnt_d    = cnt_q;
    rel_d    = rel_q;
    acc_d    = acc_q;
    result_o = '0;
    unique case (op)
      OP_TICK: begin
        if (ctrl_q[CTL_ENABLE_BIT]) begin
          acc_d = acc_next;
          if (expire) begin
            if (!flag_q) begin
              flag_d             = 1'b1;
              result_o.irq_raise = ctrl_q[CTL_IE_BIT];
            end
            cnt_d = ctrl_q[CTL_AUTO_BIT] ? (rel_q - over) : '0;
          end else begin
            cnt_d = cnt_dec;
          end
        end
      end
      OP_READ: begin
        unique case (rsel)
          REG_CONTROL: result_o.read_data = ctrl_q;
          REG_STATUS:  result_o.read_data = {15'd0, flag_q};
          REG_COUNT:   result_o.read_data = 16'(cnt_q);
          REG_RELOAD:  result_o.read_data = 16'(rel_q);
        endcase
      end
      OP_WRITE: begin
        unique case (rsel)
          REG_CONTROL: begin
            ctrl_d = item_i.write_value;
            if (item_i.write_value[CTL_LOAD_BIT]) begin
              cnt_d = rel_q;
            end
          end
          REG_STATUS: begin
            if (item_i.write_value[STS_FLAG_BIT]) begin
              flag_d             = 1'b0;
              result_o.irq_lower = ctrl_q[CTL_IE_BIT];
            end
          end
          REG_COUNT:  cnt_d = COUNT_WIDTH'(item_i.write_value);
          REG_RELOAD: rel_d = COUNT_WIDTH'(item_i.write_value);
        endcase
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      flag_q <= 1'b0;
      cnt_q  <= '0;
      rel_q  <= '0;
      acc_q  <= '0;
    end else if (fire_i) begin
      ctrl_q <= ctrl_d;
      flag_q <= flag_d;
      cnt_q  <= cnt_d;
      rel_q  <= rel_d;
      acc_q  <= acc_d;
    end
  end

  // a raised irq leaves the flag set
  a_raise_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.irq_raise |=> flag_q)
    else $error("irq raised but flag not set");

  // a raise only happens from a clear flag
  a_raise_from_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.irq_raise |-> !flag_q)
    else $error("irq raised with flag already set");

  // status write of one clears the flag
  a_status_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && op == OP_WRITE && rsel == REG_STATUS && item_i.write_value[STS_FLAG_BIT]
    |=> !flag_q)
    else $error("status clear did not clear flag");

  // read data only on reads
  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && op != OP_READ |-> result_o.read_data == '0)
    else $error("read data on non-read item");

  // state holds without an item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(cnt_q) && $stable(flag_q) && $stable(acc_q))
    else $error("timer state changed without an item");

endmodule
